// ===== rtl/semantic_value_pair_similarity_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pair similarity block
// Shared property templates used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEMANTIC_VALUE_PAIR_SIMILARITY_TOP_ASSERT_SVH
`define SEMANTIC_VALUE_PAIR_SIMILARITY_TOP_ASSERT_SVH

// Next-cycle implication, disabled while reset is held
`define SVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches the reset itself
`define SVPS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/svps_pkg.sv =====
// ----------------------------------------------------------------------------
// svps_pkg
// Shared widths, constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package svps_pkg;

  // Field and arithmetic widths
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned TOT_W      = 24;
  localparam int unsigned DEN_W      = TOT_W + 1;
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned ONE_Q15    = 32768;
  localparam int unsigned IN_TERM_W  = 6;
  localparam int unsigned IN_ANC_W   = 8;

  // Configuration register
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CFG_RESET  = 256;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_TA,
    ST_Q_TB,
    ST_Q_DEN,
    ST_WALK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } svps_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_en;
    logic ld_wr;
    logic tot_sel_b;
    logic den_load;
    logic den_add;
    logic walk_init;
    logic walk_issue;
    logic div_start;
    logic out_load;
  } svps_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic anc_ok;
    logic same_term;
    logic walk_end;
    logic den_zero;
    logic div_done;
  } svps_sts_t;

endpackage

// ===== rtl/svps_div.sv =====
// ----------------------------------------------------------------------------
// svps_div
// Restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module svps_div #(
  parameter int unsigned DVD_W = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [svps_pkg::DEN_W-1:0]   divisor,
  output logic                         done,
  output logic [DVD_W-1:0]             quotient
);
  import svps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});

  // Next state of the iteration
  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DVD_W-2:0], qbit};
      rem_nxt = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control flags under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Advance the operand registers
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ===== rtl/svps_dp.sv =====
// ----------------------------------------------------------------------------
// svps_dp
// Datapath: value table, term totals, ancestor walk accumulator, divider and
// the result register.
// ----------------------------------------------------------------------------
module svps_dp #(
  parameter int unsigned MAX_TERMS     = 64,
  parameter int unsigned MAX_ANCESTORS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  svps_pkg::svps_cmd_t             cmd,
  output svps_pkg::svps_sts_t             sts,
  input  logic [svps_pkg::IN_TERM_W-1:0]  in_term,
  input  logic [svps_pkg::IN_ANC_W-1:0]   in_ancestor,
  input  logic [svps_pkg::VAL_W-1:0]      in_value,
  input  logic [svps_pkg::IN_TERM_W-1:0]  in_other_term,
  input  logic [svps_pkg::CFG_W-1:0]      anc_in_use,
  output logic [svps_pkg::VAL_W-1:0]      out_similarity,
  output logic                            out_status
);
  import svps_pkg::*;

  localparam int unsigned TERM_W  = $clog2(MAX_TERMS);
  localparam int unsigned ANC_W   = (MAX_ANCESTORS > 1) ? $clog2(MAX_ANCESTORS) : 1;
  localparam int unsigned ROW_W   = $clog2(MAX_ANCESTORS + 1);
  localparam int unsigned ADDR_W  = ANC_W + TERM_W;
  localparam int unsigned TDEPTH  = 2 ** TERM_W;
  localparam int unsigned DEPTH   = MAX_ANCESTORS * TDEPTH;
  localparam int unsigned SUM_W   = $clog2(MAX_ANCESTORS * 2 * ONE_Q15 + 1);
  localparam int unsigned DVD_W   = SUM_W + FRAC_W;
  localparam int unsigned NCODES  = 2 ** IN_TERM_W;

  // Fold an input term code into the table's column range
  logic [TERM_W-1:0] term_mod [NCODES];
  for (genvar gi = 0; gi < NCODES; gi++) begin : g_term_mod
    assign term_mod[gi] = TERM_W'(gi % MAX_TERMS);
  end

  logic [TERM_W-1:0]  ta_r, tb_r;
  logic [ANC_W-1:0]   anc_r;
  logic               anc_ok_r;
  logic [VAL_W-1:0]   val_r;

  logic [VAL_W-1:0]   vmem [DEPTH];
  logic [TOT_W-1:0]   tmem [TDEPTH];
  logic [VAL_W-1:0]   rd_a_r, rd_b_r;
  logic [TOT_W-1:0]   rd_tot_r;
  logic [ADDR_W-1:0]  ld_addr, addr_a, addr_b;
  logic               vm_we;
  logic [ADDR_W-1:0]  vm_waddr;
  logic [VAL_W-1:0]   vm_wdata;
  logic [TOT_W-1:0]   tot_new;

  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   rows_lim;
  logic               acc_en_r;
  logic [SUM_W-1:0]   sum_r;
  logic [DEN_W-1:0]   den_r;

  logic               div_done;
  logic [DVD_W-1:0]   quo;
  logic [VAL_W-1:0]   sat_q;
  logic [VAL_W-1:0]   out_sim_r;
  logic               out_status_r;

  // Capture the request fields on acceptance
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ta_r     <= term_mod[in_term];
      tb_r     <= term_mod[in_other_term];
      anc_r    <= ANC_W'(in_ancestor);
      anc_ok_r <= (32'(in_ancestor) < MAX_ANCESTORS);
      val_r    <= (in_value > VAL_W'(ONE_Q15)) ? VAL_W'(ONE_Q15) : in_value;
    end
  end

  // Address selection for the value table
  assign ld_addr  = {anc_r, ta_r};
  assign addr_a   = cmd.walk_issue ? {row_r[ANC_W-1:0], ta_r} : ld_addr;
  assign addr_b   = {row_r[ANC_W-1:0], tb_r};
  assign vm_we    = cmd.clr_en | cmd.ld_wr;
  assign vm_waddr = cmd.clr_en ? clr_cnt_r : ld_addr;
  assign vm_wdata = cmd.clr_en ? '0 : val_r;

  // Value table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    rd_a_r <= vmem[addr_a];
    rd_b_r <= vmem[addr_b];
  end

  // Replace the old cell value in the running total
  assign tot_new = rd_tot_r - TOT_W'(rd_a_r) + TOT_W'(val_r);

  // Term totals: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      tmem[clr_cnt_r[TERM_W-1:0]] <= '0;
    end else if (cmd.ld_wr) begin
      tmem[ta_r] <= tot_new;
    end
    rd_tot_r <= tmem[cmd.tot_sel_b ? tb_r : ta_r];
  end

  // Sweep counter for the clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // Clamp the configured row count to the table height
  assign rows_lim = (32'(anc_in_use) > MAX_ANCESTORS) ? ROW_W'(MAX_ANCESTORS)
                                                       : ROW_W'(anc_in_use);

  // Walk the ancestor rows, one row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.walk_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      row_r <= '0;
    end else if (cmd.walk_issue) begin
      row_r <= row_r + ROW_W'(1);
    end
  end

  // Accumulate rows where both terms carry a value
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      sum_r <= '0;
    end else if (acc_en_r && (rd_a_r != '0) && (rd_b_r != '0)) begin
      sum_r <= sum_r + SUM_W'(rd_a_r) + SUM_W'(rd_b_r);
    end
  end

  // Denominator: sum of both term totals
  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den_r <= DEN_W'(rd_tot_r);
    end else if (cmd.den_add) begin
      den_r <= den_r + DEN_W'(rd_tot_r);
    end
  end

  svps_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sum_r, FRAC_W'(0)}),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Saturate the quotient to 1.0
  assign sat_q = (quo > DVD_W'(ONE_Q15)) ? VAL_W'(ONE_Q15) : quo[VAL_W-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (ta_r == tb_r) begin
        out_sim_r    <= VAL_W'(ONE_Q15);
        out_status_r <= 1'b0;
      end else if (den_r == '0) begin
        out_sim_r    <= '0;
        out_status_r <= 1'b1;
      end else begin
        out_sim_r    <= sat_q;
        out_status_r <= 1'b0;
      end
    end
  end

  assign out_similarity = out_sim_r;
  assign out_status     = out_status_r;

  // Status back to the controller
  assign sts.clr_last  = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign sts.anc_ok    = anc_ok_r;
  assign sts.same_term = (ta_r == tb_r);
  assign sts.walk_end  = (row_r == rows_lim);
  assign sts.den_zero  = (den_r == '0);
  assign sts.div_done  = div_done;

endmodule

// ===== rtl/svps_ctrl.sv =====
// ----------------------------------------------------------------------------
// svps_ctrl
// Controller: sequences the clearing pass, loads and queries, and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module svps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output svps_pkg::svps_cmd_t  cmd,
  input  svps_pkg::svps_sts_t  sts
);
  import svps_pkg::*;

  svps_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_mode ? ST_Q_TA : ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        state_nxt = sts.anc_ok ? ST_LD_WR : ST_IDLE;
      end
      ST_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_Q_TA: begin
        state_nxt = sts.same_term ? ST_DONE : ST_Q_TB;
      end
      ST_Q_TB: begin
        cmd.tot_sel_b = 1'b1;
        cmd.den_load  = 1'b1;
        state_nxt     = ST_Q_DEN;
      end
      ST_Q_DEN: begin
        cmd.den_add   = 1'b1;
        cmd.walk_init = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_end) begin
          state_nxt = sts.den_zero ? ST_DONE : ST_DIV_GO;
        end else begin
          cmd.walk_issue = 1'b1;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/semantic_value_pair_similarity_top.sv =====
// ----------------------------------------------------------------------------
// semantic_value_pair_similarity_top
// Pair similarity over a table of Q1.15 semantic values per term and ancestor.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the value table, one cell
// per cycle, and stalls requests until it ends; register writes are taken
// throughout. A load request reads the old cell and total, then writes both;
// an ancestor outside the table is dropped without a write. A query walks
// one ancestor row per cycle through a dual-read value table and then runs
// a restoring divider at one quotient bit per cycle; the rows walked are
// ancestors_in_use, clamped to MAX_ANCESTORS. Equal terms skip the walk and
// the divider, and a zero denominator skips the divider. One request is in
// work at a time; a finished result waits in an output register, so the
// next request is accepted while the previous result is still stalled.
// ----------------------------------------------------------------------------
module semantic_value_pair_similarity_top #(
  parameter int unsigned MAX_TERMS     = 64,
  parameter int unsigned MAX_ANCESTORS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [svps_pkg::IN_TERM_W-1:0]    in_term,
  input  logic [svps_pkg::IN_ANC_W-1:0]     in_ancestor,
  input  logic [svps_pkg::VAL_W-1:0]        in_value,
  input  logic [svps_pkg::IN_TERM_W-1:0]    in_other_term,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svps_pkg::VAL_W-1:0]        out_similarity,
  output logic                              out_status,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [svps_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [svps_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [svps_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import svps_pkg::*;

  localparam int unsigned REG_IDX_W      = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ANC_IN_USE = '0;

  logic [CFG_W-1:0]     anc_cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  svps_cmd_t            cmd;
  svps_sts_t            sts;

  // Register decode on the word address
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_cfg_r <= CFG_W'(CFG_RESET);
    end else if (cfg_wr && (reg_idx == REG_ANC_IN_USE)) begin
      anc_cfg_r <= pwdata[CFG_W-1:0];
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_ANC_IN_USE: prdata = APB_DATA_W'(anc_cfg_r);
      default:        prdata = '0;
    endcase
  end

  svps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  svps_dp #(
    .MAX_TERMS     (MAX_TERMS),
    .MAX_ANCESTORS (MAX_ANCESTORS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_term        (in_term),
    .in_ancestor    (in_ancestor),
    .in_value       (in_value),
    .in_other_term  (in_other_term),
    .anc_in_use     (anc_cfg_r),
    .out_similarity (out_similarity),
    .out_status     (out_status)
  );

endmodule

// ===== rtl/svps_chk.sv =====
// ----------------------------------------------------------------------------
// svps_chk
// Port-level checker for the pair similarity block, bound to the top level.
// ----------------------------------------------------------------------------
`include "semantic_value_pair_similarity_top_assert.svh"

module svps_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_mode,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [svps_pkg::VAL_W-1:0]        out_similarity,
  input  logic                              out_status
);
  import svps_pkg::*;

  logic             in_acc;
  logic             ld_acc;
  logic             out_held;
  logic [VAL_W:0]   out_word;

  // Handshake terms and the result payload as one word
  assign in_acc   = in_valid && !in_stall;
  assign ld_acc   = in_acc && !in_mode;
  assign out_held = out_valid && out_stall;
  assign out_word = {out_similarity, out_status};

  // A stalled result stays put
  `SVPS_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled result moved")

  // Requests stall straight after reset, when the clearing pass begins
  `SVPS_ASSERT_RST(a_clear_stalls, !rst_n, in_stall, "request port open straight after reset")

  // An accepted request keeps the block busy in the next cycle
  `SVPS_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "request accepted back to back")

  // A load never raises a result
  `SVPS_ASSERT_NEXT(a_load_silent, ld_acc && !out_valid, !out_valid, "load produced a result")

endmodule

bind semantic_value_pair_similarity_top svps_chk u_svps_chk (.*);
